>>> rtl/core/nmea_sfp_pkg.sv
// types, constants and helper functions for the nmea sentence field parser
package nmea_sfp_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RMC,
        KIND_GGA,
        KIND_VTG
    } kind_t;

    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_W        = 8'h57;

    localparam logic [23:0] TYPE_RMC = 24'h524D43;
    localparam logic [23:0] TYPE_GGA = 24'h474741;
    localparam logic [23:0] TYPE_VTG = 24'h565447;

    localparam int SLOT_FIRST   = 1;
    localparam int SLOT_LAST    = 9;
    localparam int FIELD_LONG   = 9;
    localparam int FIELD_VTG    = 7;
    localparam int LEN_TYPE_LO  = 3;
    localparam int LEN_TYPE_MID = 4;
    localparam int LEN_TYPE_HI  = 5;
    localparam int LEN_TYPE_END = 6;

    localparam logic [29:0] INT_CAP = 30'd999999999;
    localparam logic [23:0] HI_CAP  = 24'd9999999;
    localparam logic [6:0]  LO_CAP  = 7'd99;
    localparam logic [2:0]  FRAC_DIG_MAX = 3'd7;

    localparam logic [10:0] MULT_KNOT  = 11'd1852;
    localparam logic [10:0] MULT_MILLI = 11'd1000;
    localparam logic [10:0] MULT_CENTI = 11'd100;

    localparam logic [23:0] TEN7        = 24'd10000000;
    localparam logic [30:0] RECIP_60    = 31'd1145324613;
    localparam int          RECIP_60_SH = 36;
    localparam logic [28:0] RECIP_78125 = 29'd450359963;
    localparam int          RECIP_78125_SH = 45;

    localparam logic [47:0] LAT_MAX      = 48'd900000000;
    localparam logic [47:0] LON_MAX      = 48'd1800000000;
    localparam logic [41:0] SPEED_MAX    = 42'd9999999;
    localparam logic [41:0] HEADING_MAX  = 42'd999999;
    localparam logic [41:0] DILUTION_MAX = 42'd9999;
    localparam logic [41:0] ALT_MAX      = 42'd10000000;

    typedef struct packed {
        logic [29:0] ival;
        logic [23:0] hi;
        logic [6:0]  lo;
        logic [23:0] frac;
        logic [7:0]  low8;
        logic        neg;
        logic [7:0]  first;
    } slot_t;

    typedef struct packed {
        logic [23:0] hi;
        logic [6:0]  lo;
        logic [23:0] frac;
        logic        neg;
    } geo_in_t;

    typedef struct packed {
        logic [29:0] ival;
        logic [23:0] frac;
        logic        neg;
        logic [10:0] mult;
    } sc_in_t;

    typedef struct packed {
        logic [47:0] qd;
        logic [29:0] x;
        logic        neg;
    } geo_mid_t;

    typedef struct packed {
        logic [47:0] qd;
        logic [24:0] y;
        logic        neg;
    } geo_end_t;

    typedef struct packed {
        logic [40:0] ip;
        logic [34:0] t;
        logic        neg;
    } sc_mid_t;

    typedef struct packed {
        logic [40:0] ip;
        logic [11:0] fr;
        logic        neg;
    } sc_end_t;

    typedef struct packed {
        kind_t      kind;
        logic       fix_a;
        logic [7:0] q_fix;
        logic [7:0] q_sat;
    } tag_t;

    // weight of the next fraction digit
    function automatic logic [19:0] frac_place(input logic [2:0] n);
        logic [19:0] p;
        case (n)
            3'd0:    p = 20'd1000000;
            3'd1:    p = 20'd100000;
            3'd2:    p = 20'd10000;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd100;
            3'd5:    p = 20'd10;
            3'd6:    p = 20'd1;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

    // hundreds digit of a value below one thousand
    function automatic logic [3:0] tens_carry(input logic [9:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (v >= 10'(k * 100))
            begin
                c = 4'(k);
            end
        end
        return c;
    endfunction

    function automatic geo_in_t make_geo(input slot_t s, input logic flip);
        geo_in_t g;
        g.hi   = s.hi;
        g.lo   = s.lo;
        g.frac = s.frac;
        g.neg  = s.neg ^ flip;
        return g;
    endfunction

    function automatic sc_in_t make_sc(input slot_t s, input logic [10:0] mult);
        sc_in_t c;
        c.ival = s.ival;
        c.frac = s.frac;
        c.neg  = s.neg;
        c.mult = mult;
        return c;
    endfunction

    function automatic logic [7:0] signed_low8(input slot_t s);
        return s.neg ? 8'(8'd0 - s.low8) : s.low8;
    endfunction

endpackage

>>> rtl/core/nmea_sentence_field_parser_core.sv
// nmea sentence framing, field parsing and fixed point record update
//
//  channel | signals                      | meaning
//  --------+------------------------------+--------------------------------------
//  in      | in_valid, in_stall, rx_byte  | one received byte per request
//  out     | out_valid, out_stall, fields | kind and held record per ended line
//
// one byte is taken every cycle while in_stall is low; a line end passes through
// three close stages (field pick, scaling, reciprocal multiply), then add and clamp
// reset leaves no line open and the held record at zero
// in_stall rises only while all close stages and the output register hold requests and out_stall is high
module nmea_sentence_field_parser_core #(
    parameter int LINE_LIMIT  = 128,
    parameter int FIELD_LIMIT = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         sentence_kind,
    output logic               fix_valid,
    output logic signed [30:0] latitude,
    output logic signed [31:0] longitude,
    output logic [23:0]        ground_speed,
    output logic [19:0]        heading,
    output logic [7:0]         fix_quality,
    output logic [7:0]         satellite_count,
    output logic [13:0]        dilution,
    output logic signed [24:0] altitude
);

    localparam int LEN_W = $clog2(LINE_LIMIT);
    localparam int FLD_W = $clog2(FIELD_LIMIT);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_LIMIT - 1);
    localparam logic [FLD_W-1:0] FLD_LAST = FLD_W'(FIELD_LIMIT - 1);
    localparam logic [FLD_W-1:0] FLD_LONG = FLD_W'(nmea_sfp_pkg::FIELD_LONG);
    localparam logic [FLD_W-1:0] FLD_VTG  = FLD_W'(nmea_sfp_pkg::FIELD_VTG);

    // line parser state
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [FLD_W-1:0]     fld_reg, fld_next;
    logic [23:0]          type_reg, type_next;
    nmea_sfp_pkg::slot_t  cur_reg, cur_next;
    nmea_sfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]           fdig_reg, fdig_next;
    logic                 started_reg, started_next;
    nmea_sfp_pkg::slot_t  pend_reg [nmea_sfp_pkg::SLOT_FIRST:nmea_sfp_pkg::SLOT_LAST];
    nmea_sfp_pkg::slot_t  pend_next [nmea_sfp_pkg::SLOT_FIRST:nmea_sfp_pkg::SLOT_LAST];

    // close stages
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    nmea_sfp_pkg::tag_t      s1_tag_reg, s1_tag_next, s2_tag_reg, s3_tag_reg;
    nmea_sfp_pkg::geo_in_t   s1_g0_reg, s1_g1_reg, s1_g0_next, s1_g1_next;
    nmea_sfp_pkg::sc_in_t    s1_c0_reg, s1_c1_reg, s1_c0_next, s1_c1_next;
    nmea_sfp_pkg::geo_mid_t  s2_g0_reg, s2_g1_reg, s2_g0_next, s2_g1_next;
    nmea_sfp_pkg::sc_mid_t   s2_c0_reg, s2_c1_reg, s2_c0_next, s2_c1_next;
    nmea_sfp_pkg::geo_end_t  s3_g0_reg, s3_g1_reg, s3_g0_next, s3_g1_next;
    nmea_sfp_pkg::sc_end_t   s3_c0_reg, s3_c1_reg, s3_c0_next, s3_c1_next;

    // held record and output
    logic                    out_valid_reg;
    nmea_sfp_pkg::kind_t     kind_reg;
    logic                    fixv_reg, fixv_next;
    logic signed [30:0]      lat_reg, lat_next;
    logic signed [31:0]      lon_reg, lon_next;
    logic [23:0]             speed_reg, speed_next;
    logic [19:0]             head_reg, head_next;
    logic [7:0]              qual_reg, qual_next;
    logic [7:0]              sats_reg, sats_next;
    logic [13:0]             dil_reg, dil_next;
    logic signed [24:0]      alt_reg, alt_next;

    logic out_free, rdy1, rdy2, rdy3, accept, close_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign rdy3     = !s3_valid_reg || out_free;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;
    assign accept   = in_valid && rdy1;

    // byte handling and field parsing
    always_comb
    begin
        logic                 digit;
        logic [3:0]           dval;
        nmea_sfp_pkg::slot_t  take;
        nmea_sfp_pkg::phase_t take_ph;
        logic [2:0]           take_fd;
        logic [33:0]          acc;
        logic [9:0]           lo_t;
        logic [3:0]           cy;
        logic [26:0]          hi_t;
        logic                 pre_frac;

        digit    = rx_byte inside {[nmea_sfp_pkg::CH_ZERO:nmea_sfp_pkg::CH_NINE]};
        dval     = digit ? rx_byte[3:0] : 4'd0;
        take     = cur_reg;
        take_ph  = phase_reg;
        take_fd  = fdig_reg;
        pre_frac = (phase_reg == nmea_sfp_pkg::PH_LEAD) || (phase_reg == nmea_sfp_pkg::PH_SIGN)
                   || (phase_reg == nmea_sfp_pkg::PH_INT);
        acc  = {1'b0, cur_reg.ival, 3'b0} + {3'b0, cur_reg.ival, 1'b0} + {30'd0, dval};
        lo_t = {cur_reg.lo, 3'b0} + {2'b0, cur_reg.lo, 1'b0} + {6'd0, dval};
        cy   = nmea_sfp_pkg::tens_carry(lo_t);
        hi_t = {cur_reg.hi, 3'b0} + {2'b0, cur_reg.hi, 1'b0} + {23'd0, cy};

        if (!started_reg)
        begin
            take.first = rx_byte;
        end
        if (pre_frac && digit)
        begin
            take_ph = nmea_sfp_pkg::PH_INT;
            if (acc > {4'd0, nmea_sfp_pkg::INT_CAP})
            begin
                take.ival = nmea_sfp_pkg::INT_CAP;
                take.hi   = nmea_sfp_pkg::HI_CAP;
                take.lo   = nmea_sfp_pkg::LO_CAP;
            end
            else
            begin
                take.ival = acc[29:0];
                take.hi   = hi_t[23:0];
                take.lo   = 7'(lo_t - ({6'd0, cy} * 10'd100));
            end
            take.low8 = 8'({cur_reg.low8, 3'b0} + {2'b0, cur_reg.low8, 1'b0} + {7'd0, dval});
        end
        else if (pre_frac && rx_byte == nmea_sfp_pkg::CH_DOT)
        begin
            take_ph = nmea_sfp_pkg::PH_FRAC;
        end
        else if (phase_reg == nmea_sfp_pkg::PH_LEAD && rx_byte == nmea_sfp_pkg::CH_SPACE)
        begin
            take_ph = phase_reg;
        end
        else if (phase_reg == nmea_sfp_pkg::PH_LEAD
                 && (rx_byte == nmea_sfp_pkg::CH_PLUS || rx_byte == nmea_sfp_pkg::CH_MINUS))
        begin
            take_ph  = nmea_sfp_pkg::PH_SIGN;
            take.neg = (rx_byte == nmea_sfp_pkg::CH_MINUS);
        end
        else if (phase_reg == nmea_sfp_pkg::PH_FRAC && digit)
        begin
            take.frac = cur_reg.frac
                        + 24'({20'd0, dval} * {4'd0, nmea_sfp_pkg::frac_place(fdig_reg)});
            if (fdig_reg != nmea_sfp_pkg::FRAC_DIG_MAX)
            begin
                take_fd = fdig_reg + 3'd1;
            end
        end
        else
        begin
            take_ph = nmea_sfp_pkg::PH_STOP;
        end

        len_next     = len_reg;
        fld_next     = fld_reg;
        type_next    = type_reg;
        cur_next     = cur_reg;
        phase_next   = phase_reg;
        fdig_next    = fdig_reg;
        started_next = started_reg;
        pend_next    = pend_reg;
        close_fire   = 1'b0;

        if (accept)
        begin
            if (rx_byte == nmea_sfp_pkg::CH_DOLLAR)
            begin
                len_next     = LEN_W'(1);
                fld_next     = '0;
                type_next    = '0;
                cur_next     = '0;
                phase_next   = nmea_sfp_pkg::PH_LEAD;
                fdig_next    = '0;
                started_next = 1'b0;
                for (int k = nmea_sfp_pkg::SLOT_FIRST; k <= nmea_sfp_pkg::SLOT_LAST; k++)
                begin
                    pend_next[k] = '0;
                end
            end
            else if (rx_byte == nmea_sfp_pkg::CH_CR || rx_byte == nmea_sfp_pkg::CH_LF)
            begin
                if (len_reg != '0)
                begin
                    close_fire = 1'b1;
                    len_next   = '0;
                end
            end
            else if (rx_byte >= nmea_sfp_pkg::CH_PRINT_LO && rx_byte <= nmea_sfp_pkg::CH_PRINT_HI
                     && len_reg != '0)
            begin
                if (len_reg >= LEN_LAST)
                begin
                    len_next = '0;
                end
                else
                begin
                    if (len_reg == LEN_W'(nmea_sfp_pkg::LEN_TYPE_LO))
                    begin
                        type_next[23:16] = rx_byte;
                    end
                    if (len_reg == LEN_W'(nmea_sfp_pkg::LEN_TYPE_MID))
                    begin
                        type_next[15:8] = rx_byte;
                    end
                    if (len_reg == LEN_W'(nmea_sfp_pkg::LEN_TYPE_HI))
                    begin
                        type_next[7:0] = rx_byte;
                    end
                    if ((rx_byte == nmea_sfp_pkg::CH_COMMA || rx_byte == nmea_sfp_pkg::CH_STAR)
                        && fld_reg < FLD_LAST)
                    begin
                        for (int k = nmea_sfp_pkg::SLOT_FIRST; k <= nmea_sfp_pkg::SLOT_LAST; k++)
                        begin
                            if (fld_reg == FLD_W'(k))
                            begin
                                pend_next[k] = cur_reg;
                            end
                        end
                        fld_next     = fld_reg + FLD_W'(1);
                        cur_next     = '0;
                        phase_next   = nmea_sfp_pkg::PH_LEAD;
                        fdig_next    = '0;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        cur_next     = take;
                        phase_next   = take_ph;
                        fdig_next    = take_fd;
                        started_next = 1'b1;
                    end
                    len_next = len_reg + LEN_W'(1);
                end
            end
            else
            begin
                len_next = '0;
            end
        end
    end

    // line close: pick the fields that the sentence kind needs
    always_comb
    begin
        nmea_sfp_pkg::slot_t eff [nmea_sfp_pkg::SLOT_FIRST:nmea_sfp_pkg::SLOT_LAST];
        nmea_sfp_pkg::kind_t kind;

        for (int k = nmea_sfp_pkg::SLOT_FIRST; k <= nmea_sfp_pkg::SLOT_LAST; k++)
        begin
            eff[k] = (fld_reg == FLD_W'(k)) ? cur_reg : pend_reg[k];
        end

        kind = nmea_sfp_pkg::KIND_NONE;
        if (len_reg >= LEN_W'(nmea_sfp_pkg::LEN_TYPE_END))
        begin
            if (type_reg == nmea_sfp_pkg::TYPE_RMC && fld_reg >= FLD_LONG)
            begin
                kind = nmea_sfp_pkg::KIND_RMC;
            end
            else if (type_reg == nmea_sfp_pkg::TYPE_GGA && fld_reg >= FLD_LONG)
            begin
                kind = nmea_sfp_pkg::KIND_GGA;
            end
            else if (type_reg == nmea_sfp_pkg::TYPE_VTG && fld_reg >= FLD_VTG)
            begin
                kind = nmea_sfp_pkg::KIND_VTG;
            end
        end

        s1_tag_next.kind  = kind;
        s1_tag_next.fix_a = (eff[2].first == nmea_sfp_pkg::CH_A);
        s1_tag_next.q_fix = nmea_sfp_pkg::signed_low8(eff[6]);
        s1_tag_next.q_sat = nmea_sfp_pkg::signed_low8(eff[7]);

        case (kind)
            nmea_sfp_pkg::KIND_GGA:
            begin
                s1_g0_next = nmea_sfp_pkg::make_geo(eff[2], eff[3].first == nmea_sfp_pkg::CH_S);
                s1_g1_next = nmea_sfp_pkg::make_geo(eff[4], eff[5].first == nmea_sfp_pkg::CH_W);
                s1_c0_next = nmea_sfp_pkg::make_sc(eff[8], nmea_sfp_pkg::MULT_CENTI);
                s1_c1_next = nmea_sfp_pkg::make_sc(eff[9], nmea_sfp_pkg::MULT_CENTI);
            end
            nmea_sfp_pkg::KIND_VTG:
            begin
                s1_g0_next = nmea_sfp_pkg::make_geo(eff[3], 1'b0);
                s1_g1_next = nmea_sfp_pkg::make_geo(eff[5], 1'b0);
                s1_c0_next = nmea_sfp_pkg::make_sc(eff[7], nmea_sfp_pkg::MULT_MILLI);
                s1_c1_next = nmea_sfp_pkg::make_sc(eff[1], nmea_sfp_pkg::MULT_MILLI);
            end
            default:
            begin
                s1_g0_next = nmea_sfp_pkg::make_geo(eff[3], eff[4].first == nmea_sfp_pkg::CH_S);
                s1_g1_next = nmea_sfp_pkg::make_geo(eff[5], eff[6].first == nmea_sfp_pkg::CH_W);
                s1_c0_next = nmea_sfp_pkg::make_sc(eff[7], nmea_sfp_pkg::MULT_KNOT);
                s1_c1_next = nmea_sfp_pkg::make_sc(eff[8], nmea_sfp_pkg::MULT_MILLI);
            end
        endcase
    end

    // degrees and minute remainder scaled, value and fraction scaled
    always_comb
    begin
        s2_g0_next.qd  = {24'd0, s1_g0_reg.hi} * {24'd0, nmea_sfp_pkg::TEN7};
        s2_g0_next.x   = 30'(({24'd0, s1_g0_reg.lo} * {7'd0, nmea_sfp_pkg::TEN7})
                             + {7'd0, s1_g0_reg.frac});
        s2_g0_next.neg = s1_g0_reg.neg;
        s2_g1_next.qd  = {24'd0, s1_g1_reg.hi} * {24'd0, nmea_sfp_pkg::TEN7};
        s2_g1_next.x   = 30'(({24'd0, s1_g1_reg.lo} * {7'd0, nmea_sfp_pkg::TEN7})
                             + {7'd0, s1_g1_reg.frac});
        s2_g1_next.neg = s1_g1_reg.neg;
        s2_c0_next.ip  = {11'd0, s1_c0_reg.ival} * {30'd0, s1_c0_reg.mult};
        s2_c0_next.t   = {11'd0, s1_c0_reg.frac} * {24'd0, s1_c0_reg.mult};
        s2_c0_next.neg = s1_c0_reg.neg;
        s2_c1_next.ip  = {11'd0, s1_c1_reg.ival} * {30'd0, s1_c1_reg.mult};
        s2_c1_next.t   = {11'd0, s1_c1_reg.frac} * {24'd0, s1_c1_reg.mult};
        s2_c1_next.neg = s1_c1_reg.neg;
    end

    // divide by sixty and by ten million through reciprocals
    always_comb
    begin
        logic [60:0] px0, px1;
        logic [56:0] pf0, pf1;

        px0 = {31'd0, s2_g0_reg.x} * {30'd0, nmea_sfp_pkg::RECIP_60};
        px1 = {31'd0, s2_g1_reg.x} * {30'd0, nmea_sfp_pkg::RECIP_60};
        pf0 = {29'd0, s2_c0_reg.t[34:7]} * {28'd0, nmea_sfp_pkg::RECIP_78125};
        pf1 = {29'd0, s2_c1_reg.t[34:7]} * {28'd0, nmea_sfp_pkg::RECIP_78125};

        s3_g0_next.qd  = s2_g0_reg.qd;
        s3_g0_next.y   = px0[nmea_sfp_pkg::RECIP_60_SH +: 25];
        s3_g0_next.neg = s2_g0_reg.neg;
        s3_g1_next.qd  = s2_g1_reg.qd;
        s3_g1_next.y   = px1[nmea_sfp_pkg::RECIP_60_SH +: 25];
        s3_g1_next.neg = s2_g1_reg.neg;
        s3_c0_next.ip  = s2_c0_reg.ip;
        s3_c0_next.fr  = pf0[nmea_sfp_pkg::RECIP_78125_SH +: 12];
        s3_c0_next.neg = s2_c0_reg.neg;
        s3_c1_next.ip  = s2_c1_reg.ip;
        s3_c1_next.fr  = pf1[nmea_sfp_pkg::RECIP_78125_SH +: 12];
        s3_c1_next.neg = s2_c1_reg.neg;
    end

    // final sums, clamps and record update
    always_comb
    begin
        logic [47:0] gm0, gm1, gmag0, gmag1;
        logic [41:0] sm0, sm1, spd, hdg, dil, alt;

        gm0   = s3_g0_reg.qd + {23'd0, s3_g0_reg.y};
        gm1   = s3_g1_reg.qd + {23'd0, s3_g1_reg.y};
        gmag0 = (gm0 > nmea_sfp_pkg::LAT_MAX) ? nmea_sfp_pkg::LAT_MAX : gm0;
        gmag1 = (gm1 > nmea_sfp_pkg::LON_MAX) ? nmea_sfp_pkg::LON_MAX : gm1;
        sm0   = {1'b0, s3_c0_reg.ip} + {30'd0, s3_c0_reg.fr};
        sm1   = {1'b0, s3_c1_reg.ip} + {30'd0, s3_c1_reg.fr};
        spd   = (sm0 > nmea_sfp_pkg::SPEED_MAX) ? nmea_sfp_pkg::SPEED_MAX : sm0;
        dil   = (sm0 > nmea_sfp_pkg::DILUTION_MAX) ? nmea_sfp_pkg::DILUTION_MAX : sm0;
        hdg   = (sm1 > nmea_sfp_pkg::HEADING_MAX) ? nmea_sfp_pkg::HEADING_MAX : sm1;
        alt   = (sm1 > nmea_sfp_pkg::ALT_MAX) ? nmea_sfp_pkg::ALT_MAX : sm1;

        fixv_next  = fixv_reg;
        lat_next   = lat_reg;
        lon_next   = lon_reg;
        speed_next = speed_reg;
        head_next  = head_reg;
        qual_next  = qual_reg;
        sats_next  = sats_reg;
        dil_next   = dil_reg;
        alt_next   = alt_reg;

        case (s3_tag_reg.kind)
            nmea_sfp_pkg::KIND_RMC:
            begin
                fixv_next  = s3_tag_reg.fix_a;
                lat_next   = s3_g0_reg.neg ? 31'(31'd0 - gmag0[30:0]) : gmag0[30:0];
                lon_next   = s3_g1_reg.neg ? 32'(32'd0 - gmag1[31:0]) : gmag1[31:0];
                speed_next = s3_c0_reg.neg ? 24'd0 : spd[23:0];
                head_next  = s3_c1_reg.neg ? 20'd0 : hdg[19:0];
            end
            nmea_sfp_pkg::KIND_GGA:
            begin
                lat_next  = s3_g0_reg.neg ? 31'(31'd0 - gmag0[30:0]) : gmag0[30:0];
                lon_next  = s3_g1_reg.neg ? 32'(32'd0 - gmag1[31:0]) : gmag1[31:0];
                qual_next = s3_tag_reg.q_fix;
                sats_next = s3_tag_reg.q_sat;
                dil_next  = s3_c0_reg.neg ? 14'd0 : dil[13:0];
                alt_next  = s3_c1_reg.neg ? 25'(25'd0 - alt[24:0]) : alt[24:0];
            end
            nmea_sfp_pkg::KIND_VTG:
            begin
                speed_next = s3_c0_reg.neg ? 24'd0 : spd[23:0];
                head_next  = s3_c1_reg.neg ? 20'd0 : hdg[19:0];
            end
            default:
            begin
                fixv_next = fixv_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            phase_reg     <= nmea_sfp_pkg::PH_LEAD;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= nmea_sfp_pkg::KIND_NONE;
            fixv_reg      <= 1'b0;
            lat_reg       <= '0;
            lon_reg       <= '0;
            speed_reg     <= '0;
            head_reg      <= '0;
            qual_reg      <= '0;
            sats_reg      <= '0;
            dil_reg       <= '0;
            alt_reg       <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            phase_reg <= phase_next;
            if (rdy1)
            begin
                s1_valid_reg <= close_fire;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg)
                begin
                    kind_reg  <= s3_tag_reg.kind;
                    fixv_reg  <= fixv_next;
                    lat_reg   <= lat_next;
                    lon_reg   <= lon_next;
                    speed_reg <= speed_next;
                    head_reg  <= head_next;
                    qual_reg  <= qual_next;
                    sats_reg  <= sats_next;
                    dil_reg   <= dil_next;
                    alt_reg   <= alt_next;
                end
            end
        end
    end

    // payload registers, cleared by the line start where needed
    always_ff @(posedge clk)
    begin
        fld_reg     <= fld_next;
        type_reg    <= type_next;
        cur_reg     <= cur_next;
        fdig_reg    <= fdig_next;
        started_reg <= started_next;
        pend_reg    <= pend_next;
        if (rdy1)
        begin
            s1_tag_reg <= s1_tag_next;
            s1_g0_reg  <= s1_g0_next;
            s1_g1_reg  <= s1_g1_next;
            s1_c0_reg  <= s1_c0_next;
            s1_c1_reg  <= s1_c1_next;
        end
        if (rdy2)
        begin
            s2_tag_reg <= s1_tag_reg;
            s2_g0_reg  <= s2_g0_next;
            s2_g1_reg  <= s2_g1_next;
            s2_c0_reg  <= s2_c0_next;
            s2_c1_reg  <= s2_c1_next;
        end
        if (rdy3)
        begin
            s3_tag_reg <= s2_tag_reg;
            s3_g0_reg  <= s3_g0_next;
            s3_g1_reg  <= s3_g1_next;
            s3_c0_reg  <= s3_c0_next;
            s3_c1_reg  <= s3_c1_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sentence_kind   = kind_reg;
    assign fix_valid       = fixv_reg;
    assign latitude        = lat_reg;
    assign longitude       = lon_reg;
    assign ground_speed    = speed_reg;
    assign heading         = head_reg;
    assign fix_quality     = qual_reg;
    assign satellite_count = sats_reg;
    assign dilution        = dil_reg;
    assign altitude        = alt_reg;

endmodule

>>> dv/nmea_sentence_field_parser_core_test.sv
// testbench for the nmea sentence field parser core, byte stream against a line predictor
module nmea_sentence_field_parser_core_test;
    import nmea_sfp_pkg::*;

    typedef struct {
        string text;
        bit    typed;
        kind_t kind;
    } row_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        kind_t      kind;
    } rx_item_t;

    typedef struct {
        kind_t              kind;
        logic               fixv;
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic [23:0]        spd;
        logic [19:0]        hdg;
        logic [7:0]         qual;
        logic [7:0]         sats;
        logic [13:0]        dil;
        logic signed [24:0] alt;
    } line_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         sentence_kind;
    logic               fix_valid;
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic [23:0]        ground_speed;
    logic [19:0]        heading;
    logic [7:0]         fix_quality;
    logic [7:0]         satellite_count;
    logic [13:0]        dilution;
    logic signed [24:0] altitude;

    nmea_sentence_field_parser_core u_dut (.*);

    always #5 clk = ~clk;

    rx_item_t  rx_q[$];
    line_rec_t line_q[$];
    int        errors = 0;
    int        lines_done = 0;
    int        bytes_sent = 0;
    int        cyc = 0;

    // predictor state
    int unsigned    ln_len = 0, fld_no = 0, type_w = 0;
    int unsigned    sl_int[10], sl_frac[10], sl_low8[10];
    bit             sl_neg[10];
    byte unsigned   sl_first[10];
    longint         rec_lat = 0, rec_lon = 0, rec_spd = 0, rec_hdg = 0, rec_dil = 0, rec_alt = 0;
    int unsigned    rec_fix = 0;
    int unsigned    f_int, f_frac, f_place, f_low8, f_phase;
    bit             f_neg, f_started;
    byte unsigned   f_first;

    function automatic void field_reset();
        f_int = 0; f_frac = 0; f_place = 1000000; f_low8 = 0;
        f_phase = 0; f_neg = 0; f_first = 0; f_started = 0;
    endfunction

    function automatic void slots_clear();
        for (int i = 0; i < 10; i++)
        begin
            sl_int[i] = 0; sl_frac[i] = 0; sl_low8[i] = 0; sl_neg[i] = 0; sl_first[i] = 0;
        end
    endfunction

    function automatic void field_char(int unsigned c);
        bit          dig;
        int unsigned d;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d = dig ? c - CH_ZERO : 0;
        if (!f_started)
        begin
            f_first = c; f_started = 1;
        end
        if (f_phase <= 2 && dig)
        begin
            f_phase = 2;
            f_int = (f_int > (999999999 - d) / 10) ? 999999999 : f_int * 10 + d;
            f_low8 = (f_low8 * 10 + d) & 8'hFF;
        end
        else if (f_phase <= 2 && c == CH_DOT)
            f_phase = 3;
        else if (f_phase == 0 && c == CH_SPACE)
            f_phase = 0;
        else if (f_phase == 0 && (c == CH_PLUS || c == CH_MINUS))
        begin
            f_phase = 1; f_neg = (c == CH_MINUS);
        end
        else if (f_phase == 3 && dig)
        begin
            f_frac += d * f_place; f_place /= 10;
        end
        else
            f_phase = 4;
    endfunction

    function automatic void field_store();
        if (fld_no >= 1 && fld_no < 10)
        begin
            sl_int[fld_no] = f_int; sl_frac[fld_no] = f_frac; sl_low8[fld_no] = f_low8;
            sl_neg[fld_no] = f_neg; sl_first[fld_no] = f_first;
        end
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint to_fixed(int f, longint mult, longint lo, longint hi);
        longint m;
        m = longint'(sl_int[f]) * mult + longint'(sl_frac[f]) * mult / 10000000;
        return clampv(sl_neg[f] ? -m : m, lo, hi);
    endfunction

    function automatic longint to_degrees(int f, bit flip, longint lim);
        longint ip, m;
        ip = sl_int[f];
        m = (ip / 100) * 10000000 + ((ip % 100) * 10000000 + sl_frac[f]) / 60;
        if (m > lim)
            m = lim;
        return (sl_neg[f] ^ flip) ? -m : m;
    endfunction

    function automatic int unsigned count_low8(int f);
        return sl_neg[f] ? ((256 - sl_low8[f]) & 8'hFF) : sl_low8[f];
    endfunction

    function automatic kind_t close_line();
        kind_t k;
        k = KIND_NONE;
        field_store();
        if (ln_len < 6)
            return k;
        if (type_w == TYPE_RMC && fld_no + 1 >= 10)
        begin
            k = KIND_RMC;
            rec_fix = (rec_fix & 32'hFFFF) | ((sl_first[2] == CH_A) ? 32'h10000 : 0);
            rec_lat = to_degrees(3, sl_first[4] == CH_S, 900000000);
            rec_lon = to_degrees(5, sl_first[6] == CH_W, 1800000000);
            rec_spd = to_fixed(7, 1852, 0, 9999999);
            rec_hdg = to_fixed(8, 1000, 0, 999999);
        end
        else if (type_w == TYPE_GGA && fld_no + 1 >= 10)
        begin
            k = KIND_GGA;
            rec_lat = to_degrees(2, sl_first[3] == CH_S, 900000000);
            rec_lon = to_degrees(4, sl_first[5] == CH_W, 1800000000);
            rec_fix = (rec_fix & 32'h10000) | (count_low8(6) << 8) | count_low8(7);
            rec_dil = to_fixed(8, 100, 0, 9999);
            rec_alt = to_fixed(9, 100, -10000000, 10000000);
        end
        else if (type_w == TYPE_VTG && fld_no + 1 >= 8)
        begin
            k = KIND_VTG;
            rec_hdg = to_fixed(1, 1000, 0, 999999);
            rec_spd = to_fixed(7, 1000, 0, 9999999);
        end
        return k;
    endfunction

    function automatic void parse_byte(rx_item_t it);
        int unsigned c;
        line_rec_t   r;
        c = it.b;
        if (c == CH_DOLLAR)
        begin
            ln_len = 1; fld_no = 0; type_w = 0;
            slots_clear(); field_reset();
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            if (ln_len != 0)
            begin
                r.kind = close_line();
                if (it.typed)
                    r.kind = it.kind;
                ln_len = 0;
                r.fixv = rec_fix[16];
                r.lat  = rec_lat[30:0];
                r.lon  = rec_lon[31:0];
                r.spd  = rec_spd[23:0];
                r.hdg  = rec_hdg[19:0];
                r.qual = rec_fix[15:8];
                r.sats = rec_fix[7:0];
                r.dil  = rec_dil[13:0];
                r.alt  = rec_alt[24:0];
                line_q.push_back(r);
            end
        end
        else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI && ln_len > 0)
        begin
            if (ln_len >= 127)
                ln_len = 0;
            else
            begin
                if (ln_len >= 3 && ln_len <= 5)
                    type_w |= c << (8 * (5 - ln_len));
                if ((c == CH_COMMA || c == CH_STAR) && fld_no < 19)
                begin
                    field_store(); fld_no++; field_reset();
                end
                else
                    field_char(c);
                ln_len++;
            end
        end
        else
            ln_len = 0;
    endfunction

    function automatic bit idle_now();
        return ((cyc % 5000) >= 1500) && ($urandom_range(0, 99) < 20);
    endfunction

    // request side
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                begin
                    parse_byte(rx_q.pop_front());
                    bytes_sent++;
                end
                if (rx_q.size() > 0 && !idle_now())
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_q[0].b;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= idle_now();
        end
    end

    function automatic void check_field(string nm, longint e, longint a);
        if (e != a)
        begin
            errors++;
            $display("%0t %s expected %0d actual %0d", $time, nm, e, a);
        end
    endfunction

    // result side
    always @(posedge clk)
    begin
        line_rec_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result expected none actual kind %0d", $time,
                         sentence_kind);
            end
            else
            begin
                e = line_q.pop_front();
                check_field("sentence_kind", e.kind, sentence_kind);
                check_field("fix_valid", e.fixv, fix_valid);
                check_field("latitude", e.lat, latitude);
                check_field("longitude", e.lon, longitude);
                check_field("ground_speed", e.spd, ground_speed);
                check_field("heading", e.hdg, heading);
                check_field("fix_quality", e.qual, fix_quality);
                check_field("satellite_count", e.sats, satellite_count);
                check_field("dilution", e.dil, dilution);
                check_field("altitude", e.alt, altitude);
            end
            lines_done++;
        end
    end

    function automatic void push_text(string s, bit typed, kind_t k);
        rx_item_t it;
        for (int i = 0; i < s.len(); i++)
        begin
            it.b = s[i];
            it.typed = typed && (i == s.len() - 1);
            it.kind = k;
            rx_q.push_back(it);
        end
    endfunction

    function automatic string rand_num();
        string s;
        s = "";
        if ($urandom_range(0, 7) == 0)
            return s;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            s = {s, " "};
        case ($urandom_range(0, 5))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
        endcase
        repeat ($urandom_range(0, 5) == 0 ? $urandom_range(6, 12) : $urandom_range(0, 5))
            s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 2) != 0)
        begin
            s = {s, "."};
            repeat ($urandom_range(0, 10))
                s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        if ($urandom_range(0, 9) == 0)
            s = {s, "x1"};
        return s;
    endfunction

    function automatic string rand_letter(string set);
        int i;
        i = $urandom_range(0, set.len() - 1);
        return set.substr(i, i);
    endfunction

    function automatic string rand_line();
        string s, ends[4];
        int    n;
        ends = '{"\015", "\n", "\015\n", "\n\015"};
        s = {"$", rand_letter("GN"), rand_letter("PN")};
        case ($urandom_range(0, 9))
            0, 1, 2: s = {s, "RMC,", rand_num(), ",", rand_letter("AVA"), ",", rand_num(), ",",
                          rand_letter("NSX"), ",", rand_num(), ",", rand_letter("EWX"), ",",
                          rand_num(), ",", rand_num(), ",", rand_num(), ",", rand_num(), ",",
                          rand_letter("EW")};
            3, 4, 5: s = {s, "GGA,", rand_num(), ",", rand_num(), ",", rand_letter("NSX"), ",",
                          rand_num(), ",", rand_letter("EWX"), ",", rand_num(), ",", rand_num(),
                          ",", rand_num(), ",", rand_num(), ",M,", rand_num(), ",M,,"};
            6, 7, 8: s = {s, "VTG,", rand_num(), ",T,", rand_num(), ",M,", rand_num(), ",N,",
                          rand_num(), ",K"};
            default: s = {s, rand_letter("GRV"), rand_letter("SMT"), rand_letter("VCG"), ",",
                          rand_num()};
        endcase
        if ($urandom_range(0, 7) == 0)
            s = s.substr(0, $urandom_range(0, s.len() - 1));
        if ($urandom_range(0, 1) == 0)
            s = {s, "*", $sformatf("%02X", $urandom_range(0, 255))};
        return {s, ends[$urandom_range(0, 3)]};
    endfunction

    initial
    begin
        row_t     rows[$];
        string    s, fill126;
        rx_item_t it;
        int       n_lines;
        fill126 = "$GPVTG";
        while (fill126.len() < 127)
            fill126 = {fill126, "0"};
        rows = '{
            '{"\n", 0, KIND_NONE},
            '{"$GP\n", 1, KIND_NONE},
            '{"$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\015",
              1, KIND_RMC},
            '{"\n", 0, KIND_NONE},
            '{"$GPGGA,123519,4807.038,S,01131.000,W,1,08,0.9,-545.4,M,46.9,M,,*47\n",
              1, KIND_GGA},
            '{"$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K*48\n", 1, KIND_VTG},
            '{"$GPRMC,0,V,99999999999.99999999,S,-18000.5,W,-5,99999999,0,0,0*00\n",
              1, KIND_RMC},
            '{"$GPGGA,0,9000.0,N,18000.0,E,-1,300,  -3.25,999999,M*0\n", 1, KIND_GGA},
            '{"$GPGGA,0,-9999.9999999,N,+99999.9,W,255,+256,99.999,-999999,M*0\n",
              1, KIND_GGA},
            '{"$GPRMC,1,A,2*\n", 1, KIND_NONE},
            '{"$GPXYZ,1,2,3,4,5,6,7,8,9,10\n", 1, KIND_NONE},
            '{"$GPRMC,1\001,A\n", 0, KIND_NONE},
            '{"$GPGGA\200,\n", 0, KIND_NONE},
            '{"$GPVTG,,,,,,,,,,,,,,,,,,,,,,,,,1.5\n", 1, KIND_VTG},
            '{"$GPGGA,1,$GPVTG,1,T,,M,2,N,3,K\n", 1, KIND_VTG},
            '{"$GPVTG,1.5.5,T,,M,,N,x7,K\n", 1, KIND_VTG},
            '{{fill126.substr(0, 125), "\n"}, 0, KIND_NONE},
            '{{fill126, "\n"}, 0, KIND_NONE},
            '{{fill126, "0\n"}, 0, KIND_NONE}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
            push_text(rows[i].text, rows[i].typed, rows[i].kind);
        n_lines = 0;
        while (rx_q.size() + bytes_sent < 400 + 300 || n_lines < 60)
        begin
            s = rand_line();
            for (int i = 0; i < s.len(); i++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    it.b = $urandom_range(0, 255);
                    it.typed = 0;
                    rx_q.push_back(it);
                end
                it.b = s[i];
                it.typed = 0;
                rx_q.push_back(it);
            end
            n_lines++;
        end
        wait (rx_q.size() == 0 && !in_valid);
        wait (line_q.size() == 0);
        repeat (20) @(posedge clk);
        if (line_q.size() != 0)
        begin
            errors++;
            $display("%0t leftover results expected 0 actual %0d", $time, line_q.size());
        end
        $display("ran %0d bytes of directed and random nmea lines, %0d line results checked",
                 bytes_sent, lines_done);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
